// File: sv/spectrum_magnitude_peak_finder_macros.svh
// Assertion shorthands shared by the peak finder modules.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef SPECTRUM_MAGNITUDE_PEAK_FINDER_MACROS_SVH
`define SPECTRUM_MAGNITUDE_PEAK_FINDER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SMPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SMPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/smpf_pkg.sv
`timescale 1ns / 1ps

package smpf_pkg;

    // configuration register widths and indexes
    localparam int FRAME_SIZE_W = 13;
    localparam int RATE_W       = 32;
    localparam int CENTER_W     = 36;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 36;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_SIZE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_RATE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_FREQ = 2'd2;

    localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RST = 13'd1024;

    // result field widths
    localparam int BIN_W       = 12;
    localparam int MAG_W       = 16;
    localparam int FREQ_W      = 38;
    localparam int OUT_FIELD_W = BIN_W + MAG_W + BIN_W + FREQ_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SQRT,
        S_UPDATE,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic square;
        logic sqrt_step;
        logic update;
        logic mul;
        logic div_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic last;
        logic out_busy;
    } t_dp_sts;

endpackage

// File: sv/spectrum_magnitude_peak_finder.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Payload
// s (bins)  in   i_s_tvalid / o_s_tready   i_s_tdata: real_part, imag_part
// m (res)   out  o_m_tvalid / i_m_tready   o_m_tdata + o_m_tlast (frame_end)
// cfg       in   i_cfg_we                  i_cfg_addr, i_cfg_data
//
// Each bin passes through the bit-serial square root that yields one
// magnitude bit per cycle. The last bin of a frame also runs the multiply and
// the shift-subtract division that places the peak frequency.
// A new bin is taken as soon as the previous one sits in the output register;
// a stalled output holds the next result in the datapath until it drains.
// Reset is synchronous, active low; frame_size returns to 1024, rates to 0.

module spectrum_magnitude_peak_finder
    import smpf_pkg::*;
#(
    parameter int MAX_BINS     = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // configuration writes: 0 frame_size, 1 sample_rate, 2 center_frequency
    input  logic                                       i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]                      i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]                      i_cfg_data,
    // bins in
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    // real_part, imag_part (each SAMPLE_WIDTH bits, signed), zero padded
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        i_s_tdata,
    // results out
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    // bin_number[11:0], magnitude[27:12], peak_bin[39:28],
    // peak_frequency[77:40], zeros[79:78]
    output logic [OUT_TDATA_W-1:0]                     o_m_tdata,
    output logic                                       o_m_tlast
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequence one bin at a time: square, root, peak update, then the
    // once-per-frame multiply and divide, then hand off to the output register
    smpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // registers, root and divide iterations, frame tracking, output stage
    smpf_dp #(
        .MAX_BINS     (MAX_BINS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_re        (i_s_tdata[SAMPLE_WIDTH-1:0]),
        .i_im        (i_s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_data  (o_m_tdata),
        .o_out_last  (o_m_tlast)
    );

endmodule

// File: sv/smpf_ctrl.sv
`timescale 1ns / 1ps
`include "spectrum_magnitude_peak_finder_macros.svh"

module smpf_ctrl
    import smpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.last ? S_MUL : S_EMIT;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // wait for the output register to free up
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `SMPF_ASSERT_NEXT(a_accept_to_square, o_cmd.load_in, r_state == S_SQUARE, "accept did not start squaring")
    `SMPF_ASSERT_NEXT(a_div_to_emit, o_cmd.div_step && i_sts.div_done, r_state == S_EMIT, "division end lost")
    `SMPF_ASSERT_NOW(a_emit_free, o_cmd.emit, !i_sts.out_busy, "emit over a pending result")

endmodule

// File: sv/smpf_dp.sv
`timescale 1ns / 1ps
`include "spectrum_magnitude_peak_finder_macros.svh"

module smpf_dp
    import smpf_pkg::*;
#(
    parameter int MAX_BINS     = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]          i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] i_re,
    input  logic signed [SAMPLE_WIDTH-1:0] i_im,
    input  t_dp_cmd                        i_cmd,
    output t_dp_sts                        o_sts,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [OUT_TDATA_W-1:0]         o_out_data,
    output logic                           o_out_last
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int XW    = 2 * SW;
    localparam int RW    = SW + 2;
    localparam int SQC_W = $clog2(SW);
    localparam int CNT_W = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
    localparam int EW    = (CNT_W + 1 > FRAME_SIZE_W) ? CNT_W + 1 : FRAME_SIZE_W;
    localparam int PW    = RATE_W + CNT_W;
    localparam int DVC_W = $clog2(PW);

    // configuration
    logic [FRAME_SIZE_W-1:0] r_frame_size;
    logic [RATE_W-1:0]       r_rate;
    logic [CENTER_W-1:0]     r_center;

    // frame state
    logic [CNT_W-1:0] r_bin_cnt;
    logic [SW-1:0]    r_best_mag;
    logic [CNT_W-1:0] r_best_bin;

    // per-item working registers
    logic signed [SW-1:0] r_re;
    logic signed [SW-1:0] r_im;
    logic [XW-1:0]        r_x;
    logic [RW-1:0]        r_rem;
    logic [SW-1:0]        r_root;
    logic [SQC_W-1:0]     r_sq_cnt;
    logic [PW-1:0]        r_dvq;
    logic [CNT_W-1:0]     r_drem;
    logic [DVC_W-1:0]     r_dv_cnt;

    // output register
    logic                r_out_valid;
    logic [BIN_W-1:0]    r_out_bin;
    logic [MAG_W-1:0]    r_out_mag;
    logic                r_out_last;
    logic [BIN_W-1:0]    r_out_pbin;
    logic [FREQ_W-1:0]   r_out_freq;

    logic [EW-1:0]        fs_ext;
    logic [CNT_W-1:0]     size_m1;
    logic                 last;
    logic signed [XW-1:0] sq_re;
    logic signed [XW-1:0] sq_im;
    logic [RW-1:0]        rem_sh;
    logic [RW-1:0]        trial;
    logic [CNT_W:0]       drem_sh;
    logic [FREQ_W-1:0]    freq;
    logic                 fs_write;

    // effective frame size minus one, saturated to 2..MAX_BINS bins
    assign fs_ext = EW'(r_frame_size);
    always_comb begin
        if (fs_ext < EW'(2)) begin
            size_m1 = CNT_W'(1);
        end else if (fs_ext > EW'(MAX_BINS)) begin
            size_m1 = CNT_W'(MAX_BINS - 1);
        end else begin
            size_m1 = CNT_W'(fs_ext - EW'(1));
        end
    end

    assign last     = (r_bin_cnt >= size_m1);
    assign fs_write = i_cfg_we && (i_cfg_addr == CFG_FRAME_SIZE);

    assign sq_re  = r_re * r_re;
    assign sq_im  = r_im * r_im;

    // one root bit per step
    assign rem_sh  = {r_rem[SW-1:0], r_x[XW-1 -: 2]};
    assign trial   = {r_root[SW-1:0], 2'b01};
    assign drem_sh = {r_drem, r_dvq[PW-1]};

    assign freq = FREQ_W'(r_center) + FREQ_W'(r_dvq[RATE_W-1:0])
                - FREQ_W'(r_rate[RATE_W-1:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_size <= FRAME_SIZE_RST;
            r_rate       <= '0;
            r_center     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FRAME_SIZE:  r_frame_size <= i_cfg_data[FRAME_SIZE_W-1:0];
                CFG_SAMPLE_RATE: r_rate       <= i_cfg_data[RATE_W-1:0];
                CFG_CENTER_FREQ: r_center     <= i_cfg_data[CENTER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || fs_write) begin
            r_bin_cnt  <= '0;
            r_best_mag <= '0;
            r_best_bin <= '0;
        end else begin
            if (i_cmd.update && (r_root > r_best_mag)) begin
                r_best_mag <= r_root;
                r_best_bin <= r_bin_cnt;
            end
            if (i_cmd.emit) begin
                if (last) begin
                    r_bin_cnt  <= '0;
                    r_best_mag <= '0;
                    r_best_bin <= '0;
                end else begin
                    r_bin_cnt <= r_bin_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_re <= i_re;
            r_im <= i_im;
        end
        if (i_cmd.square) begin
            r_x      <= $unsigned(sq_re) + $unsigned(sq_im);
            r_rem    <= '0;
            r_root   <= '0;
            r_sq_cnt <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_x      <= {r_x[XW-3:0], 2'b00};
            r_sq_cnt <= r_sq_cnt + SQC_W'(1);
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[SW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[SW-2:0], 1'b0};
            end
        end
        if (i_cmd.mul) begin
            r_dvq    <= r_rate * r_best_bin;
            r_drem   <= '0;
            r_dv_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dv_cnt <= r_dv_cnt + DVC_W'(1);
            if (drem_sh >= {1'b0, size_m1}) begin
                r_drem <= CNT_W'(drem_sh - {1'b0, size_m1});
                r_dvq  <= {r_dvq[PW-2:0], 1'b1};
            end else begin
                r_drem <= drem_sh[CNT_W-1:0];
                r_dvq  <= {r_dvq[PW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_bin  <= BIN_W'(r_bin_cnt);
            r_out_mag  <= MAG_W'(r_root);
            r_out_last <= last;
            r_out_pbin <= last ? BIN_W'(r_best_bin) : '0;
            r_out_freq <= last ? freq : '0;
        end
    end

    assign o_sts.sqrt_done = (r_sq_cnt == SQC_W'(SW - 1));
    assign o_sts.div_done  = (r_dv_cnt == DVC_W'(PW - 1));
    assign o_sts.last      = last;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;
    assign o_out_data  = {{OUT_PAD_W{1'b0}}, r_out_freq, r_out_pbin, r_out_mag, r_out_bin};

    `SMPF_ASSERT_NOW(a_cnt_in_frame, 1'b1, r_bin_cnt <= size_m1, "bin counter beyond frame")
    `SMPF_ASSERT_NEXT(a_frame_restart, i_cmd.emit && last, (r_bin_cnt == '0) && (r_best_mag == '0), "frame did not restart")
    `SMPF_ASSERT_NEXT(a_best_grows, !(i_cmd.emit && last) && !fs_write, r_best_mag >= $past(r_best_mag), "peak magnitude fell mid-frame")
    `SMPF_ASSERT_NEXT(a_emit_shows, i_cmd.emit, r_out_valid, "emitted result not shown")

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

// Stream testbench for the spectrum magnitude peak finder.
// Bins go in on the s side and results come back on the m side. Each accepted
// bin is run through a local model of the block, and every result transfer is
// checked against the oldest pending prediction.

module tb;
    import smpf_pkg::*;

    localparam int MAX_BINS     = 4096;
    localparam int SAMPLE_W     = 16;
    localparam int RANDOM_ITEMS = 1250;
    localparam int BIG_PHASE    = 6;      // phase that runs on the clamped 4096-bin frame
    localparam int BIG_ITEMS    = 200;    // bins sent in that phase
    localparam int LONG_HOLD    = 300;    // cycles the sink holds off once
    localparam int STALL_LIMIT  = 5000;   // cycles with no transfer before giving up
    localparam int SETTLE       = 80;     // covers the slowest bin plus the divide
    localparam int MAX_REPORTS  = 30;

    // index 3 decodes to no register, so writes to it must be dropped
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [BIN_W-1:0]  bin_number;
        logic [MAG_W-1:0]  magnitude;
        logic              frame_end;
        logic [BIN_W-1:0]  peak_bin;
        logic [FREQ_W-1:0] peak_frequency;
    } t_bin_result;

    typedef enum logic {
        ROW_BIN,
        ROW_CFG
    } t_row_kind;

    // one line of the directed table: either a bin or a register write
    typedef struct packed {
        t_row_kind                  kind;
        logic [CFG_ADDR_W-1:0]      addr;
        logic [CFG_DATA_W-1:0]      data;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       chk_mag;
        logic [MAG_W-1:0]           mag;
        logic                       chk_freq;
        logic [FREQ_W-1:0]          freq;
    } t_dir_row;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0]         i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    // real_part[15:0], imag_part[31:16]
    logic [2*SAMPLE_W-1:0]         i_s_tdata  = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    // bin_number[11:0], magnitude[27:12], peak_bin[39:28],
    // peak_frequency[77:40], zeros[79:78]
    logic [OUT_TDATA_W-1:0]        o_m_tdata;
    logic                          o_m_tlast;

    spectrum_magnitude_peak_finder #(
        .MAX_BINS     (MAX_BINS),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Local model of the block: registers plus per-frame peak tracking
    // ------------------------------------------------------------------
    logic [FRAME_SIZE_W-1:0] frame_size_q = FRAME_SIZE_RST;
    logic [RATE_W-1:0]       rate_q       = '0;
    logic [CENTER_W-1:0]     center_q     = '0;
    logic [BIN_W-1:0]        bin_idx_q    = '0;
    logic [MAG_W:0]          best_mag_q   = '0;
    logic [BIN_W-1:0]        best_bin_q   = '0;

    t_bin_result pending_q[$];
    t_dir_row    dir_q[$];
    int          errors = 0;
    bit          hold_req = 1'b0;
    int          burst_left = 0;

    // floor square root by setting result bits from the top down
    function automatic logic [MAG_W-1:0] bin_magnitude(input logic signed [SAMPLE_W-1:0] re,
                                                       input logic signed [SAMPLE_W-1:0] im);
        longint r2;
        longint root;
        longint trial;
        r2   = longint'(re) * longint'(re) + longint'(im) * longint'(im);
        root = 0;
        for (int b = MAG_W; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= r2)
                root = trial;
        end
        return root[MAG_W-1:0];
    endfunction

    // frame length actually used: the register clamped to 2..MAX_BINS
    function automatic int unsigned bins_per_frame();
        if (frame_size_q < 2)
            return 2;
        if (frame_size_q > MAX_BINS)
            return MAX_BINS;
        return 32'(frame_size_q);
    endfunction

    // advance the model by one bin and return the result it must produce
    function automatic t_bin_result predict_bin(input logic signed [SAMPLE_W-1:0] re,
                                                input logic signed [SAMPLE_W-1:0] im);
        t_bin_result res;
        logic [MAG_W-1:0] mag;
        int unsigned span;
        logic [63:0] offset;
        logic [63:0] freq;
        mag  = bin_magnitude(re, im);
        span = bins_per_frame();
        res  = '0;
        res.bin_number = bin_idx_q;
        res.magnitude  = mag;
        // strict compare: a tie keeps the earlier bin
        if (mag > best_mag_q) begin
            best_mag_q = (MAG_W+1)'(mag);
            best_bin_q = bin_idx_q;
        end
        if (32'(bin_idx_q) + 1 >= span) begin
            offset = (64'(rate_q) * 64'(best_bin_q)) / 64'(span - 1);
            freq   = 64'(center_q) + offset - 64'(rate_q >> 1);
            res.frame_end      = 1'b1;
            res.peak_bin       = best_bin_q;
            res.peak_frequency = freq[FREQ_W-1:0];
            bin_idx_q  = '0;
            best_mag_q = '0;
            best_bin_q = '0;
        end else begin
            bin_idx_q = bin_idx_q + 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Write one register; only called while nothing is in flight.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (addr)
            CFG_FRAME_SIZE: begin
                // a new size restarts the frame
                frame_size_q = data[FRAME_SIZE_W-1:0];
                bin_idx_q    = '0;
                best_mag_q   = '0;
                best_bin_q   = '0;
            end
            CFG_SAMPLE_RATE: rate_q = data[RATE_W-1:0];
            CFG_CENTER_FREQ: center_q = data[CENTER_W-1:0];
            default: ;
        endcase
    endtask

    // Hold until every predicted result has drained.
    task automatic wait_idle();
        while (pending_q.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Offer one bin, honoring the burst/gap pattern, and return its prediction
    // once the transfer has happened.
    task automatic send_bin(input logic signed [SAMPLE_W-1:0] re,
                            input logic signed [SAMPLE_W-1:0] im,
                            output t_bin_result res);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {im, re};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        res = predict_bin(re, im);
    endtask

    task automatic put_bin(input logic signed [SAMPLE_W-1:0] re,
                           input logic signed [SAMPLE_W-1:0] im,
                           input logic chk_mag, input logic [MAG_W-1:0] mag,
                           input logic chk_freq = 1'b0, input logic [FREQ_W-1:0] freq = '0);
        t_dir_row row;
        row          = '0;
        row.kind     = ROW_BIN;
        row.re       = re;
        row.im       = im;
        row.chk_mag  = chk_mag;
        row.mag      = mag;
        row.chk_freq = chk_freq;
        row.freq     = freq;
        dir_q.push_back(row);
    endtask

    task automatic put_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        t_dir_row row;
        row      = '0;
        row.kind = ROW_CFG;
        row.addr = addr;
        row.data = data;
        dir_q.push_back(row);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] extreme_value();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    // Mix of full-range, small, extreme, zero and scaled samples; some repeat
    // the previous magnitude with signs or parts swapped to force peak ties.
    function automatic logic [2*SAMPLE_W-1:0] pick_sample(input logic [2*SAMPLE_W-1:0] prev);
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                re = 16'($urandom);
                im = 16'($urandom);
            end
            4: begin
                re = 16'($urandom_range(0, 16) - 8);
                im = 16'($urandom_range(0, 16) - 8);
            end
            5: begin
                re = extreme_value();
                im = extreme_value();
            end
            6: begin
                re = prev[SAMPLE_W-1:0];
                im = prev[2*SAMPLE_W-1:SAMPLE_W];
                case ($urandom_range(0, 2))
                    0: {re, im} = {im, re};
                    1: re = -re;
                    default: im = -im;
                endcase
            end
            7: begin
                re = '0;
                im = '0;
            end
            default: begin
                re = $signed(16'($urandom)) >>> $urandom_range(0, 15);
                im = $signed(16'($urandom)) >>> $urandom_range(0, 15);
            end
        endcase
        return {im, re};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_frame_size();
        case ($urandom_range(0, 31))
            0: return 36'd0;
            1: return 36'd1;
            2: return 36'h1FFF;
            3: return 36'($urandom_range(4097, 8191));
            4: return 36'd4096;
            5: return 36'($urandom_range(25, 300));
            default: return 36'($urandom_range(2, 24));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return 36'd0;
            1: return 36'hFFFF_FFFF;
            2: return 36'($urandom_range(1, 1000));
            default: return 36'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_center();
        case ($urandom_range(0, 5))
            0: return 36'd0;
            1: return 36'hF_FFFF_FFFF;
            2: return 36'($urandom_range(0, 100000));
            default: return {4'($urandom_range(0, 15)), 32'($urandom)};
        endcase
    endfunction

    initial begin : stim
        t_bin_result res;
        t_dir_row row;
        logic [2*SAMPLE_W-1:0] smp;
        int total;
        int n;
        int ph;
        smp   = '0;
        total = 0;
        ph    = 0;

        // hold reset low, then release it once for good
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Start on the reset settings (1024 bins, zero rates),
        // then cut the frame short and walk the frequency extremes.
        put_bin(0, 0, 1, 0);
        put_bin(3, 4, 1, 5);
        put_bin(-32768, -32768, 1, 46340);
        put_bin(32767, 32767, 1, 46339);
        put_bin(32767, 0, 1, 32767);
        put_bin(-32768, 0, 1, 32768);
        put_bin(0, -32768, 1, 32768);
        put_bin(-1, -1, 1, 1);
        // below the legal range, so two bins per frame; restarts mid-frame
        put_cfg(CFG_FRAME_SIZE, 36'd1);
        put_bin(5, 0, 1, 5);
        put_bin(0, -5, 1, 5, 1, 38'd0);                  // tie keeps bin 0
        put_cfg(CFG_SAMPLE_RATE, 36'hFFFF_FFFF);
        put_bin(0, 0, 1, 0);
        put_bin(0, 0, 1, 0, 1, -38'sd2147483647);        // all-zero frame, lowest frequency
        put_cfg(CFG_CENTER_FREQ, 36'hF_FFFF_FFFF);
        put_bin(0, 0, 1, 0);
        put_bin(0, 1, 1, 1, 1, 38'd70866960383);         // highest frequency
        put_cfg(CFG_UNUSED, 36'hF_FFFF_FFFF);            // must change nothing
        put_bin(0, 0, 1, 0);
        put_bin(1, 0, 1, 1, 1, 38'd70866960383);
        put_cfg(CFG_FRAME_SIZE, 36'd0);

        foreach (dir_q[i]) begin
            row = dir_q[i];
            if (row.kind == ROW_CFG) begin
                i_s_tvalid <= 1'b0;
                wait_idle();
                write_reg(row.addr, row.data);
            end else begin
                send_bin(row.re, row.im, res);
                if (row.chk_mag)
                    res.magnitude = row.mag;
                if (row.chk_freq)
                    res.peak_frequency = row.freq;
                pending_q.push_back(res);
            end
        end

        // Random phases: drain, rewrite some registers, stream a batch of
        // bins. Phase boundaries fall mid-frame, so rate and center writes
        // land inside frames too. One phase sets the size to 8191, clamped
        // to 4096 bins, and carries the long sink hold-off.
        while (total < RANDOM_ITEMS) begin
            i_s_tvalid <= 1'b0;
            wait_idle();
            if (ph == BIG_PHASE) begin
                write_reg(CFG_FRAME_SIZE, 36'h1FFF);
                write_reg(CFG_SAMPLE_RATE, pick_rate());
                write_reg(CFG_CENTER_FREQ, pick_center());
                n = BIG_ITEMS;
            end else begin
                if ($urandom_range(0, 2) == 0)
                    write_reg(CFG_FRAME_SIZE, pick_frame_size());
                if ($urandom_range(0, 1) == 0)
                    write_reg(CFG_SAMPLE_RATE, pick_rate());
                if ($urandom_range(0, 1) == 0)
                    write_reg(CFG_CENTER_FREQ, pick_center());
                if ($urandom_range(0, 15) == 0)
                    write_reg(CFG_UNUSED, {4'($urandom), 32'($urandom)});
                n = $urandom_range(5, 60);
            end
            for (int k = 0; k < n; k++) begin
                smp = pick_sample(smp);
                if (ph == BIG_PHASE && k == 64)
                    hold_req = 1'b1;
                send_bin(smp[SAMPLE_W-1:0], smp[2*SAMPLE_W-1:SAMPLE_W], res);
                pending_q.push_back(res);
                total++;
            end
            ph++;
        end

        i_s_tvalid <= 1'b0;
        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sink side: ready pattern that changes in stretches, plus one long
    // hold-off while the source keeps offering, so the block backs up.
    // ------------------------------------------------------------------
    initial begin : sink
        int mode;
        int stretch;
        int hold;
        bit hold_done;
        int tick;
        mode      = 0;
        stretch   = 0;
        hold      = 0;
        hold_done = 1'b0;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_req && !hold_done) begin
                hold      = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                i_m_tready <= 1'b0;
            end else begin
                if (stretch == 0) begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(20, 200);
                end
                stretch--;
                case (mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= 1'($urandom);
                    2: i_m_tready <= ($urandom_range(0, 4) == 0);
                    default: i_m_tready <= ((tick % 5) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: every transfer against the oldest prediction
    // ------------------------------------------------------------------
    task automatic flag_field(input string name, input logic [FREQ_W-1:0] want,
                              input logic [FREQ_W-1:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check
        t_bin_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result transfer with nothing pending, expected none actual %0h",
                             $time, o_m_tdata);
            end else begin
                want = pending_q.pop_front();
                flag_field("bin_number", want.bin_number, o_m_tdata[11:0]);
                flag_field("magnitude", want.magnitude, o_m_tdata[27:12]);
                flag_field("frame_end", want.frame_end, o_m_tlast);
                flag_field("peak_bin", want.peak_bin, o_m_tdata[39:28]);
                flag_field("peak_frequency", want.peak_frequency, o_m_tdata[77:40]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up after too long with no transfer on either side
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
